[sv/uart_register_datagram_framer_macros.svh]
// Assertion helpers used by the framer back end.
`ifndef UART_REGISTER_DATAGRAM_FRAMER_MACROS_SVH
`define UART_REGISTER_DATAGRAM_FRAMER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define URDF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define URDF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[sv/urdf_pkg.sv]
`timescale 1ns / 1ps
package urdf_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'h05;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] MASTER_ADDR = 8'hff;
    localparam logic [7:0] WRITE_FLAG  = 8'h80;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_RX    = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_REG_BIT7  = 3'd1;
    localparam logic [2:0] ST_BAD_MASTER = 3'd2;
    localparam logic [2:0] ST_BAD_SYNC  = 3'd3;
    localparam logic [2:0] ST_BAD_CRC   = 3'd4;

    // Byte position of the CRC within each datagram, and echo lengths in bytes
    localparam logic [2:0] TX_LAST_WRITE = 3'd7;
    localparam logic [2:0] TX_LAST_READ  = 3'd3;
    localparam logic [3:0] ECHO_WRITE    = 4'd8;
    localparam logic [3:0] ECHO_READ     = 4'd4;
    localparam logic [2:0] RX_CRC_POS    = 3'd7;

    localparam int BODY_BYTES  = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  slave_addr;
        logic [6:0]  reg_addr;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  tx_byte;
        logic        last_byte;
        logic [6:0]  reply_reg;
        logic [31:0] reply_data;
        logic [2:0]  reply_status;
    } t_out;

    // Classified command: datagram body for requests, received byte in body[0]
    typedef struct packed {
        logic                       is_tx;
        logic                       is_write;
        logic [BODY_BYTES-1:0][7:0] body;
    } t_cmd;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[7] ^ data[k];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

[sv/urdf_front.sv]
`timescale 1ns / 1ps
module urdf_front (
    input  logic          i_in_valid,
    input  urdf_pkg::t_in i_in,
    input  logic          i_q_full,
    output logic          o_in_stall,
    output logic          o_push,
    output urdf_pkg::t_cmd o_cmd
);
    import urdf_pkg::*;

    assign o_in_stall = i_q_full;
    // Drop the unused request code without queueing anything
    assign o_push = i_in_valid && !i_q_full && (i_in.req_type != REQ_NONE);

    always_comb begin
        o_cmd = '0;
        unique case (i_in.req_type)
            REQ_WRITE: begin
                o_cmd.is_tx    = 1'b1;
                o_cmd.is_write = 1'b1;
                o_cmd.body[0]  = i_in.slave_addr;
                o_cmd.body[1]  = {1'b0, i_in.reg_addr} | WRITE_FLAG;
                o_cmd.body[2]  = i_in.write_data[31:24];
                o_cmd.body[3]  = i_in.write_data[23:16];
                o_cmd.body[4]  = i_in.write_data[15:8];
                o_cmd.body[5]  = i_in.write_data[7:0];
            end
            REQ_READ: begin
                o_cmd.is_tx   = 1'b1;
                o_cmd.body[0] = i_in.slave_addr;
                o_cmd.body[1] = {1'b0, i_in.reg_addr};
            end
            default: begin
                o_cmd.body[0] = i_in.rx_byte;
            end
        endcase
    end

endmodule

[sv/urdf_queue.sv]
`timescale 1ns / 1ps
module urdf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  urdf_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output urdf_pkg::t_cmd o_cmd
);
    import urdf_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wptr;
    logic [QUEUE_PTR_W-1:0] r_rptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            // Wrap at the last entry so any depth works
            if (i_push) begin
                r_wptr <= (r_wptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_wptr + QUEUE_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : r_rptr + QUEUE_PTR_W'(1);
            end
            r_count <= r_count + QUEUE_CNT_W'(i_push) - QUEUE_CNT_W'(i_pop);
        end
    end

endmodule

[sv/urdf_back.sv]
`timescale 1ns / 1ps
module urdf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_q_valid,
    input  urdf_pkg::t_cmd i_q_cmd,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output urdf_pkg::t_out o_out
);
    import urdf_pkg::*;
`include "uart_register_datagram_framer_macros.svh"

    logic                       r_echo_en;
    // transmit serializer
    logic                       r_busy;
    logic                       r_is_write;
    logic [2:0]                 r_pos;
    logic [7:0]                 r_tx_crc;
    logic [BODY_BYTES-1:0][7:0] r_body;
    // reply framing
    logic [3:0]                 r_echo_left;
    logic [2:0]                 r_rx_index;
    logic [7:0]                 r_rx_crc;
    logic [7:0]                 r_rx_sync;
    logic [7:0]                 r_rx_master;
    logic [7:0]                 r_rx_reg;
    logic [31:0]                r_rx_value;
    // output register
    logic                       r_out_valid;
    t_out                       r_out;

    logic       w_out_ready;
    logic       w_emit_tx;
    logic       w_tx_last;
    logic [2:0] w_last_pos;
    logic [2:0] w_body_idx;
    logic [7:0] w_tx_byte;
    logic [7:0] w_rx;
    logic [2:0] w_status;

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign o_pop       = !r_busy && i_q_valid && w_out_ready;
    assign w_emit_tx   = r_busy && w_out_ready;
    assign w_last_pos  = r_is_write ? TX_LAST_WRITE : TX_LAST_READ;
    assign w_tx_last   = (r_pos == w_last_pos);
    assign w_body_idx  = r_pos - 3'd1;
    assign w_tx_byte   = w_tx_last ? r_tx_crc : r_body[w_body_idx];
    assign w_rx        = i_q_cmd.body[0];

    always_comb begin
        priority if (r_rx_reg[7]) begin
            w_status = ST_REG_BIT7;
        end else if (r_rx_master != MASTER_ADDR) begin
            w_status = ST_BAD_MASTER;
        end else if (r_rx_sync != SYNC_BYTE) begin
            w_status = ST_BAD_SYNC;
        end else if (w_rx != r_rx_crc) begin
            w_status = ST_BAD_CRC;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_cmd.is_tx) begin
            r_body <= i_q_cmd.body;
        end
        if (o_pop && !i_q_cmd.is_tx && r_echo_left == '0) begin
            unique case (r_rx_index)
                3'd0:    r_rx_sync   <= w_rx;
                3'd1:    r_rx_master <= w_rx;
                3'd2:    r_rx_reg    <= w_rx;
                3'd7:    ;
                default: r_rx_value  <= {r_rx_value[23:0], w_rx};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_en   <= 1'b1;
            r_busy      <= 1'b0;
            r_is_write  <= 1'b0;
            r_pos       <= '0;
            r_tx_crc    <= '0;
            r_echo_left <= '0;
            r_rx_index  <= '0;
            r_rx_crc    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_echo_en <= i_cfg_wdata;
            end
            if (w_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_emit_tx) begin
                r_out             <= '0;
                r_out.result_kind <= KIND_TX;
                r_out.tx_byte     <= w_tx_byte;
                r_out.last_byte   <= w_tx_last;
                r_out_valid       <= 1'b1;
                r_tx_crc          <= crc8_feed(r_tx_crc, w_tx_byte);
                r_pos             <= r_pos + 3'd1;
                if (w_tx_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (o_pop) begin
                if (i_q_cmd.is_tx) begin
                    // Send the sync byte now, the rest from the serializer
                    r_out             <= '0;
                    r_out.result_kind <= KIND_TX;
                    r_out.tx_byte     <= SYNC_BYTE;
                    r_out_valid       <= 1'b1;
                    r_busy            <= 1'b1;
                    r_is_write        <= i_q_cmd.is_write;
                    r_pos             <= 3'd1;
                    r_tx_crc          <= crc8_feed(8'h00, SYNC_BYTE);
                    r_rx_index        <= '0;
                    r_rx_crc          <= '0;
                    if (r_echo_en) begin
                        r_echo_left <= i_q_cmd.is_write ? ECHO_WRITE : ECHO_READ;
                    end else begin
                        r_echo_left <= '0;
                    end
                end else if (r_echo_left != '0) begin
                    r_echo_left <= r_echo_left - 4'd1;
                end else if (r_rx_index != RX_CRC_POS) begin
                    r_rx_crc   <= crc8_feed(r_rx_crc, w_rx);
                    r_rx_index <= r_rx_index + 3'd1;
                end else begin
                    r_out              <= '0;
                    r_out.result_kind  <= KIND_REPLY;
                    r_out.reply_reg    <= r_rx_reg[6:0];
                    r_out.reply_data   <= r_rx_value;
                    r_out.reply_status <= w_status;
                    r_out_valid        <= 1'b1;
                    r_rx_index         <= '0;
                    r_rx_crc           <= '0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `URDF_ASSERT(a_echo_bound, r_echo_left <= ECHO_WRITE, "echo count above datagram length")
    `URDF_ASSERT(a_busy_pos, r_busy |-> (r_pos != 3'd0 && r_pos <= w_last_pos), "tx position out of range")
    `URDF_ASSERT(a_last_ends, (w_emit_tx && w_tx_last) |=> !r_busy, "serializer busy after CRC byte")
    `URDF_ASSERT(a_last_is_tx, (r_out_valid && r_out.last_byte) |-> (r_out.result_kind == KIND_TX), "last flag on a reply")

endmodule

[sv/uart_register_datagram_framer.sv]
`timescale 1ns / 1ps
// Single-wire UART register datagram framer and reply checker. A write request
// becomes the 8-byte datagram sync 0x05, slave, reg|0x80, four data bytes MSB
// first and a CRC-8 (poly 0x07, init 0, bytes fed LSB first); a read request
// becomes sync, slave, reg, CRC. Each received byte is one input transfer: after
// a request the echo of its datagram (8 or 4 bytes) is discarded when the echo
// configuration bit is set, then every 8 bytes produce one reply result with the
// register, the data and a status (register bit 7, master 0xff, sync, CRC, first
// failure wins). Rate: the back-end serializer sends one byte per cycle while the
// output is not stalled, so a write request gives 8 bytes of output and a read
// request 4; input transfers are taken while the back end works, until the
// two-entry command queue between front and back is full; results leave
// via an output register, so an output stall fills the queue and stalls input.
// Write the configuration register only while no transfer is in flight.
module uart_register_datagram_framer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_wdata,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  urdf_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output urdf_pkg::t_out o_out
);
    import urdf_pkg::*;

    logic w_q_full;
    logic w_push;
    logic w_pop;
    logic w_q_valid;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    // Classify each transfer and build the datagram body
    urdf_front u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_q_full   (w_q_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    // Hold commands so front and back stall independently
    urdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out)
    );

    // Serialize datagrams, skip echo, frame and check replies
    urdf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_cmd_out),
        .o_pop       (w_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
